// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- hw/rtl/lrp_pkg.sv -----
// ----------------------------------------------------------------------------
// lrp_pkg
// Types, constants and table builders for the lidar return-to-point block.
// ----------------------------------------------------------------------------
package lrp_pkg;

	// field widths
	localparam int AZ_W    = 16;
	localparam int LASER_W = 6;
	localparam int DIST_W  = 16;
	localparam int INTEN_W = 8;
	localparam int COORD_W = 18;
	localparam int CFG_W   = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_JUMP   = 2'd2;

	localparam logic [CFG_W-1:0] RST_MIN_DISTANCE = 16'd1000;
	localparam logic [CFG_W-1:0] RST_MAX_DISTANCE = 16'd32500;
	localparam logic [CFG_W-1:0] RST_SWEEP_JUMP   = 16'd27000;

	// azimuth geometry, hundredths of a degree
	localparam int FULL_TURN  = 36000;
	localparam int QUARTER    = FULL_TURN / 4;
	localparam int SINE_DEPTH = QUARTER + 1;
	localparam int SINE_AW    = $clog2(SINE_DEPTH);
	localparam int SINE_W     = 16;

	localparam logic [AZ_W-1:0] AZ_Q1   = AZ_W'(QUARTER);
	localparam logic [AZ_W-1:0] AZ_Q2   = AZ_W'(2 * QUARTER);
	localparam logic [AZ_W-1:0] AZ_Q3   = AZ_W'(3 * QUARTER);
	localparam logic [AZ_W-1:0] AZ_FULL = AZ_W'(FULL_TURN);

	// lasers
	localparam int NUM_LASERS  = 2 ** LASER_W;
	localparam int BASE_LASERS = 32;
	localparam int BASE_AW     = $clog2(BASE_LASERS);

	localparam logic signed [15:0] BASE_VERT [BASE_LASERS] = '{
		-16'sd3067, -16'sd933,  -16'sd2933, -16'sd800,  -16'sd2800, -16'sd667,
		-16'sd2667, -16'sd533,  -16'sd2533, -16'sd400,  -16'sd2400, -16'sd267,
		-16'sd2267, -16'sd133,  -16'sd2133,  16'sd0,    -16'sd2000,  16'sd133,
		-16'sd1867,  16'sd267,  -16'sd1733,  16'sd400,  -16'sd1600,  16'sd533,
		-16'sd1467,  16'sd667,  -16'sd1333,  16'sd800,  -16'sd1200,  16'sd933,
		-16'sd1067,  16'sd1067
	};

	// Taylor series constants (angle in Q30)
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_STEP   = 64'(QUARTER);
	localparam logic [63:0] TWO_QUARTER = 64'(2 * QUARTER);
	localparam logic [63:0] TAYLOR_DIV [1:10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	// vertical angle entry: magnitudes plus sign of the sine
	typedef struct packed {
		logic              neg;
		logic [SINE_W-1:0] sin_mag;
		logic [SINE_W-1:0] cos_mag;
	} vert_t;

	// controller to datapath
	typedef struct packed {
		logic cap;
		logic decide;
		logic quad;
		logic mul1;
		logic mul2;
		logic load_mark;
		logic load_point;
	} lrp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic jump;
		logic keep;
		logic out_free;
	} lrp_status_t;

	// quarter-wave sine entry, scale 2^15, elaboration time only
	function automatic logic [SINE_W-1:0] build_sine(input logic [SINE_AW-1:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] q;
		x = (64'(r) * PI_Q30 + HALF_STEP) / TWO_QUARTER;
		x2 = (x * x) >> 30;
		sum = x;
		term = x;
		for (int k = 1; k <= 10; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if (k % 2 == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		q = (sum + 64'd16384) >> 15;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return q[SINE_W-1:0];
	endfunction

	// per-laser vertical trig; lasers past the base set sit at zero angle
	function automatic vert_t vert_entry(input logic [LASER_W-1:0] laser);
		logic signed [15:0] ang;
		logic [SINE_AW-1:0] mag;
		vert_t v;
		ang = (int'(laser) < BASE_LASERS) ? BASE_VERT[laser[BASE_AW-1:0]] : 16'sd0;
		mag = (ang < 0) ? SINE_AW'(-ang) : SINE_AW'(ang);
		v.sin_mag = build_sine(mag);
		v.cos_mag = build_sine(SINE_AW'(QUARTER) - mag);
		v.neg = (ang < 0) && (v.sin_mag != '0);
		return v;
	endfunction

endpackage

// ----- hw/rtl/lrp_return_if.sv -----
// ----------------------------------------------------------------------------
// lrp_return_if
// Laser return channel: valid/ready plus one return per beat.
// ----------------------------------------------------------------------------
interface lrp_return_if;
	logic                        valid;
	logic                        ready;
	logic [lrp_pkg::AZ_W-1:0]    azimuth;
	logic [lrp_pkg::LASER_W-1:0] laser;
	logic [lrp_pkg::DIST_W-1:0]  distance_raw;
	logic [lrp_pkg::INTEN_W-1:0] intensity;

	modport source (output valid, azimuth, laser, distance_raw, intensity, input ready);
	modport sink (input valid, azimuth, laser, distance_raw, intensity, output ready);
endinterface

// ----- hw/rtl/lrp_point_if.sv -----
// ----------------------------------------------------------------------------
// lrp_point_if
// Point channel: valid/ready plus one point or sweep-end marker per beat.
// ----------------------------------------------------------------------------
interface lrp_point_if;
	logic                               valid;
	logic                               ready;
	logic                               sweep_end;
	logic signed [lrp_pkg::COORD_W-1:0] x_mm;
	logic signed [lrp_pkg::COORD_W-1:0] y_mm;
	logic signed [lrp_pkg::COORD_W-1:0] z_mm;
	logic [lrp_pkg::INTEN_W-1:0]        point_intensity;

	modport source (output valid, sweep_end, x_mm, y_mm, z_mm, point_intensity, input ready);
	modport sink (input valid, sweep_end, x_mm, y_mm, z_mm, point_intensity, output ready);
endinterface

// ----- hw/rtl/lrp_sine_rom.sv -----
// ----------------------------------------------------------------------------
// lrp_sine_rom
// Quarter-wave sine ROM, two read ports with registered data.
// ----------------------------------------------------------------------------
module lrp_sine_rom (
	input  logic                         clk,
	input  logic [lrp_pkg::SINE_AW-1:0]  addr_a,
	input  logic [lrp_pkg::SINE_AW-1:0]  addr_b,
	output logic [lrp_pkg::SINE_W-1:0]   rd_a,
	output logic [lrp_pkg::SINE_W-1:0]   rd_b
);

	logic [lrp_pkg::SINE_W-1:0] rom [lrp_pkg::SINE_DEPTH];
	logic [lrp_pkg::SINE_W-1:0] rd_a_q;
	logic [lrp_pkg::SINE_W-1:0] rd_b_q;

	// contents fixed at elaboration
	for (genvar g = 0; g < lrp_pkg::SINE_DEPTH; g++) begin : g_rom
		localparam logic [lrp_pkg::SINE_W-1:0] ENTRY =
			lrp_pkg::build_sine(lrp_pkg::SINE_AW'(g));
		assign rom[g] = ENTRY;
	end

	// registered reads
	always_ff @(posedge clk) begin
		rd_a_q <= rom[addr_a];
		rd_b_q <= rom[addr_b];
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

// ----- hw/rtl/lrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrp_ctrl
// Sequencer: walks one return through decide, quadrant, ROM and multiply
// steps and issues the marker and point loads into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lrp_pkg::lrp_status_t st,
	output lrp_pkg::lrp_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_QUAD   = 3'd2;
	localparam logic [2:0] S_MARK   = 3'd3;
	localparam logic [2:0] S_ROM    = 3'd4;
	localparam logic [2:0] S_MUL1   = 3'd5;
	localparam logic [2:0] S_MUL2   = 3'd6;
	localparam logic [2:0] S_POINT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = S_QUAD;
			end
			S_QUAD: begin
				cmd.quad = 1'b1;
				if (st.jump) begin
					state_d = S_MARK;
				end else if (st.keep) begin
					state_d = S_ROM;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MARK: begin
				if (st.out_free) begin
					cmd.load_mark = 1'b1;
					state_d = st.keep ? S_ROM : S_IDLE;
				end
			end
			S_ROM: begin
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_POINT;
			end
			S_POINT: begin
				if (st.out_free) begin
					cmd.load_point = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// checks
	`ASSERT_NEVER(a_one_load, clk, arst_n, cmd.load_mark && cmd.load_point, "two output loads in one cycle")
	`ASSERT_AT(a_load_free, clk, arst_n, (cmd.load_mark || cmd.load_point) |-> st.out_free, "output register overwritten")
	`ASSERT_AT(a_accept_seq, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_DECIDE), "accepted beat not decided next")

endmodule

// ----- hw/rtl/lrp_datapath.sv -----
// ----------------------------------------------------------------------------
// lrp_datapath
// Window and sweep-jump checks, azimuth quadrant split, trig lookup,
// coordinate multiplies, rounding and the output register.
// ----------------------------------------------------------------------------
module lrp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lrp_pkg::lrp_cmd_t                   cmd,
	output lrp_pkg::lrp_status_t                st,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [lrp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lrp_pkg::CFG_W-1:0]           cfg_data,
	// return payload
	input  logic [lrp_pkg::AZ_W-1:0]            azimuth,
	input  logic [lrp_pkg::LASER_W-1:0]         laser,
	input  logic [lrp_pkg::DIST_W-1:0]          distance_raw,
	input  logic [lrp_pkg::INTEN_W-1:0]         intensity,
	// point output
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                sweep_end,
	output logic signed [lrp_pkg::COORD_W-1:0]  x_mm,
	output logic signed [lrp_pkg::COORD_W-1:0]  y_mm,
	output logic signed [lrp_pkg::COORD_W-1:0]  z_mm,
	output logic [lrp_pkg::INTEN_W-1:0]         point_intensity
);

	localparam int AW = lrp_pkg::SINE_AW;
	localparam int SW = lrp_pkg::SINE_W;
	localparam int DW = lrp_pkg::DIST_W + 1;   // distance in mm
	localparam int BW = DW + SW;               // d * cos(v)
	localparam int XW = BW + SW;               // d * cos(v) * sin/cos(a)
	localparam int CW = lrp_pkg::COORD_W;

	// configuration
	logic [lrp_pkg::CFG_W-1:0] min_q;
	logic [lrp_pkg::CFG_W-1:0] max_q;
	logic [lrp_pkg::CFG_W-1:0] jump_thr_q;

	// captured return
	logic [lrp_pkg::AZ_W-1:0]    az_q;
	logic [lrp_pkg::LASER_W-1:0] laser_q;
	logic [lrp_pkg::DIST_W-1:0]  dist_q;
	logic [lrp_pkg::INTEN_W-1:0] inten_q;

	// sweep tracking and decision
	logic [lrp_pkg::AZ_W-1:0] last_az_q;
	logic                     has_pts_q;
	logic                     jump_q;
	logic                     keep_q;
	logic [lrp_pkg::AZ_W-1:0] amod_q;
	logic [lrp_pkg::AZ_W-1:0] az_diff;
	logic                     jump_d;
	logic                     keep_d;

	// quadrant split
	logic [1:0]               quad_q;
	logic [AW-1:0]            addr_lo_q;
	logic [AW-1:0]            addr_hi_q;
	logic [1:0]               quad_d;
	logic [lrp_pkg::AZ_W-1:0] lo_d;
	logic [lrp_pkg::AZ_W-1:0] hi_d;

	// trig and products
	logic [SW-1:0]    rd_lo;
	logic [SW-1:0]    rd_hi;
	lrp_pkg::vert_t   vert_tab [lrp_pkg::NUM_LASERS];
	lrp_pkg::vert_t   vt;
	logic [DW-1:0]    dist_mm;
	logic [SW-1:0]    sa_q;
	logic [SW-1:0]    ca_q;
	logic             sneg_q;
	logic             cneg_q;
	logic             vneg_q;
	logic [BW-1:0]    base_q;
	logic [BW-1:0]    zm_q;
	logic [XW-1:0]    xm_q;
	logic [XW-1:0]    ym_q;

	// rounding
	logic [XW-1:0]    x_sum;
	logic [XW-1:0]    y_sum;
	logic [BW-1:0]    z_sum;
	logic [CW-1:0]    x_mag;
	logic [CW-1:0]    y_mag;
	logic [CW-1:0]    z_mag;

	// output register
	logic                 out_valid_q;
	logic                 sweep_end_q;
	logic [CW-1:0]        x_q;
	logic [CW-1:0]        y_q;
	logic [CW-1:0]        z_q;
	logic [lrp_pkg::INTEN_W-1:0] inten_out_q;

	// configuration writes; unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= lrp_pkg::RST_MIN_DISTANCE;
			max_q <= lrp_pkg::RST_MAX_DISTANCE;
			jump_thr_q <= lrp_pkg::RST_SWEEP_JUMP;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lrp_pkg::REG_MIN_DISTANCE: min_q <= cfg_data;
				lrp_pkg::REG_MAX_DISTANCE: max_q <= cfg_data;
				lrp_pkg::REG_SWEEP_JUMP:   jump_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			az_q <= azimuth;
			laser_q <= laser;
			dist_q <= distance_raw;
			inten_q <= intensity;
		end
	end

	// jump and window checks against the previous kept azimuth
	assign az_diff = (az_q > last_az_q) ? az_q - last_az_q : last_az_q - az_q;
	assign jump_d = has_pts_q && (az_diff > jump_thr_q);
	assign keep_d = (inten_q != '0) && (dist_q >= min_q) && (dist_q <= max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_az_q <= '0;
			has_pts_q <= 1'b0;
			jump_q <= 1'b0;
			keep_q <= 1'b0;
		end else if (cmd.decide) begin
			jump_q <= jump_d;
			keep_q <= keep_d;
			if (keep_d) begin
				last_az_q <= az_q;
				has_pts_q <= 1'b1;
			end else if (jump_d) begin
				has_pts_q <= 1'b0;
			end
		end
	end

	// one full turn folds back to zero
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			amod_q <= (az_q >= lrp_pkg::AZ_FULL) ? az_q - lrp_pkg::AZ_FULL : az_q;
		end
	end

	// quadrant, offset into it, and offset from its far end
	always_comb begin
		if (amod_q < lrp_pkg::AZ_Q1) begin
			quad_d = 2'd0;
			lo_d = amod_q;
			hi_d = lrp_pkg::AZ_Q1 - amod_q;
		end else if (amod_q < lrp_pkg::AZ_Q2) begin
			quad_d = 2'd1;
			lo_d = amod_q - lrp_pkg::AZ_Q1;
			hi_d = lrp_pkg::AZ_Q2 - amod_q;
		end else if (amod_q < lrp_pkg::AZ_Q3) begin
			quad_d = 2'd2;
			lo_d = amod_q - lrp_pkg::AZ_Q2;
			hi_d = lrp_pkg::AZ_Q3 - amod_q;
		end else begin
			quad_d = 2'd3;
			lo_d = amod_q - lrp_pkg::AZ_Q3;
			hi_d = lrp_pkg::AZ_FULL - amod_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.quad) begin
			quad_q <= quad_d;
			addr_lo_q <= lo_d[AW-1:0];
			addr_hi_q <= hi_d[AW-1:0];
		end
	end

	lrp_sine_rom u_rom (
		.clk    (clk),
		.addr_a (addr_lo_q),
		.addr_b (addr_hi_q),
		.rd_a   (rd_lo),
		.rd_b   (rd_hi)
	);

	// per-laser vertical trig, constant
	for (genvar g = 0; g < lrp_pkg::NUM_LASERS; g++) begin : g_vert
		localparam lrp_pkg::vert_t ENTRY = lrp_pkg::vert_entry(lrp_pkg::LASER_W'(g));
		assign vert_tab[g] = ENTRY;
	end

	assign vt = vert_tab[laser_q];
	assign dist_mm = {dist_q, 1'b0};

	// first multiply: d*cos(v) and d*sin(v); pick azimuth trig by quadrant
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			base_q <= BW'(dist_mm) * BW'(vt.cos_mag);
			zm_q <= BW'(dist_mm) * BW'(vt.sin_mag);
			vneg_q <= vt.neg;
			case (quad_q)
				2'd0: begin
					sa_q <= rd_lo; sneg_q <= 1'b0; ca_q <= rd_hi; cneg_q <= 1'b0;
				end
				2'd1: begin
					sa_q <= rd_hi; sneg_q <= 1'b0; ca_q <= rd_lo; cneg_q <= 1'b1;
				end
				2'd2: begin
					sa_q <= rd_lo; sneg_q <= 1'b1; ca_q <= rd_hi; cneg_q <= 1'b1;
				end
				default: begin
					sa_q <= rd_hi; sneg_q <= 1'b1; ca_q <= rd_lo; cneg_q <= 1'b0;
				end
			endcase
		end
	end

	// second multiply: horizontal components
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			xm_q <= XW'(base_q) * XW'(sa_q);
			ym_q <= XW'(base_q) * XW'(ca_q);
		end
	end

	// round half up on magnitude; sign applied after
	assign x_sum = xm_q + (XW'(1) << 29);
	assign y_sum = ym_q + (XW'(1) << 29);
	assign z_sum = zm_q + (BW'(1) << 14);
	assign x_mag = x_sum[30 +: CW];
	assign y_mag = y_sum[30 +: CW];
	assign z_mag = z_sum[15 +: CW];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_mark || cmd.load_point) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_mark) begin
			sweep_end_q <= 1'b1;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			inten_out_q <= '0;
		end else if (cmd.load_point) begin
			sweep_end_q <= 1'b0;
			x_q <= sneg_q ? (CW'(0) - x_mag) : x_mag;
			y_q <= cneg_q ? (CW'(0) - y_mag) : y_mag;
			z_q <= vneg_q ? (CW'(0) - z_mag) : z_mag;
			inten_out_q <= inten_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sweep_end = sweep_end_q;
	assign x_mm = x_q;
	assign y_mm = y_q;
	assign z_mm = z_q;
	assign point_intensity = inten_out_q;

	// status
	assign st.jump = jump_q;
	assign st.keep = keep_q;
	assign st.out_free = !out_valid_q || out_ready;

endmodule

// ----- hw/rtl/lidar_return_to_point.sv -----
// Sequencing: the block takes one return at a time and accepts the next only when idle;
//   the sequencer runs decide, quadrant, ROM read and two multiplies for a kept return,
//   and a sweep-end marker goes out before it on a jump; a dropped return ends after the
//   quadrant step or its marker. Marker and point loads wait while the output side stalls.
// Reset: arst_n clears the sequencer, sweep tracking and output valid, and loads the
//   distance window and jump threshold defaults; the trig tables are constant, no fill pass.
// ----------------------------------------------------------------------------
// lidar_return_to_point
// Spinning lidar laser return to Cartesian point, with range window and
// sweep-end detection on azimuth jumps.
// ----------------------------------------------------------------------------
module lidar_return_to_point (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [lrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrp_pkg::CFG_W-1:0]      cfg_data,
	lrp_return_if.sink                     returns,
	lrp_point_if.source                    points
);

	lrp_pkg::lrp_cmd_t    cmd;
	lrp_pkg::lrp_status_t st;

	// sequencer
	lrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (returns.valid),
		.in_ready (returns.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// arithmetic and output register
	lrp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.azimuth         (returns.azimuth),
		.laser           (returns.laser),
		.distance_raw    (returns.distance_raw),
		.intensity       (returns.intensity),
		.out_ready       (points.ready),
		.out_valid       (points.valid),
		.sweep_end       (points.sweep_end),
		.x_mm            (points.x_mm),
		.y_mm            (points.y_mm),
		.z_mm            (points.z_mm),
		.point_intensity (points.point_intensity)
	);

endmodule
